/* src/mtf_pkg.sv */
// Shared types and constants for the move-to-front list.
package mtf_pkg;

  localparam int DATA_W = 32;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_HEAD,
    ST_RESULT
  } state_t;

endpackage

/* src/mtf_mem.sv */
// Single-write, single-read list storage with registered read data.
module mtf_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [mtf_pkg::DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [mtf_pkg::DATA_W-1:0] rdata
);

  logic [mtf_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/move_to_front_list.sv */
// Move-to-front list: sequencer, entry count, shared comparator and storage.
//
// Usage: drive action and value and raise start; the item is taken at the
// rising edge where start is high and busy is low. busy stays high until the
// result has been shown. Exactly one result follows each item: done is high
// for one cycle with found and dropped valid in that same cycle. The
// receiver cannot stall; a result must be taken when done is high.
// Append: the write is made in the accept cycle, then done is shown.
// A full list refuses the value and reports dropped.
// Search: the storage is read one entry per cycle from the head and compared
// by a single 32-bit comparator until a hit or the end of the list; an empty
// list goes straight to the result, and a hit at the head writes nothing. A
// hit at position p > 0 shifts the p entries ahead of it back one place,
// then writes the value at the head. The single write port of the storage
// sets the shift rate of one entry per cycle.
// Reset (rst, synchronous) empties the list and returns to idle; stored
// entries are not cleared since nothing reads beyond the count.
module move_to_front_list #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        action,
  input  logic signed [31:0] value,
  output logic        busy,
  output logic        done,
  output logic        found,
  output logic        dropped
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  mtf_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [mtf_pkg::DATA_W-1:0] val, val_next;
  logic hit, hit_next;
  logic drop, drop_next;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [mtf_pkg::DATA_W-1:0] wdata;
  logic [AW-1:0]              raddr;
  logic [mtf_pkg::DATA_W-1:0] rdata;

  logic [CW-1:0] idx_p1, idx_m1, idx_m2;
  logic match, full, accept;

  assign idx_p1 = idx + CW'(1);
  assign idx_m1 = idx - CW'(1);
  assign idx_m2 = idx - CW'(2);
  assign match  = (rdata == val);
  assign full   = (count == CAP);
  assign accept = start && (state == mtf_pkg::ST_IDLE);

  mtf_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mtf_pkg::ST_IDLE: begin
        if (start) begin
          if (action == mtf_pkg::ACT_APPEND || count == '0) begin
            state_next = mtf_pkg::ST_RESULT;
          end else begin
            state_next = mtf_pkg::ST_SCAN;
          end
        end
      end
      mtf_pkg::ST_SCAN: begin
        if (match) begin
          state_next = (idx == '0) ? mtf_pkg::ST_RESULT : mtf_pkg::ST_SHIFT;
        end else if (idx_p1 == count) begin
          state_next = mtf_pkg::ST_RESULT;
        end
      end
      mtf_pkg::ST_SHIFT: begin
        if (idx == CW'(1)) begin
          state_next = mtf_pkg::ST_HEAD;
        end
      end
      mtf_pkg::ST_HEAD:   state_next = mtf_pkg::ST_RESULT;
      mtf_pkg::ST_RESULT: state_next = mtf_pkg::ST_IDLE;
      default:            state_next = mtf_pkg::ST_IDLE;
    endcase
  end

  // datapath and storage control
  always_comb begin
    we         = 1'b0;
    waddr      = idx[AW-1:0];
    wdata      = rdata;
    raddr      = idx[AW-1:0];
    count_next = count;
    idx_next   = idx;
    val_next   = val;
    hit_next   = hit;
    drop_next  = drop;
    case (state)
      mtf_pkg::ST_IDLE: begin
        raddr = '0;
        if (start) begin
          val_next  = value;
          idx_next  = '0;
          hit_next  = 1'b0;
          drop_next = 1'b0;
          if (action == mtf_pkg::ACT_APPEND) begin
            if (full) begin
              drop_next = 1'b1;
            end else begin
              we         = 1'b1;
              waddr      = count[AW-1:0];
              wdata      = value;
              count_next = count + CW'(1);
            end
          end
        end
      end
      mtf_pkg::ST_SCAN: begin
        if (match) begin
          hit_next = 1'b1;
          raddr    = idx_m1[AW-1:0];
        end else begin
          idx_next = idx_p1;
          raddr    = idx_p1[AW-1:0];
        end
      end
      mtf_pkg::ST_SHIFT: begin
        // entry idx-1 was read last cycle; move it back one place
        we       = 1'b1;
        waddr    = idx[AW-1:0];
        wdata    = rdata;
        idx_next = idx_m1;
        raddr    = idx_m2[AW-1:0];
      end
      mtf_pkg::ST_HEAD: begin
        we    = 1'b1;
        waddr = '0;
        wdata = val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtf_pkg::ST_IDLE;
      count <= '0;
      hit   <= 1'b0;
      drop  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      hit   <= hit_next;
      drop  <= drop_next;
    end
    idx <= idx_next;
    val <= val_next;
  end

  assign busy    = (state != mtf_pkg::ST_IDLE);
  assign done    = (state == mtf_pkg::ST_RESULT);
  assign found   = hit;
  assign dropped = drop;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("entry count above capacity");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(found && dropped))
    else $error("found and dropped both set");

  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && action == mtf_pkg::ACT_APPEND && !full) |=>
      (count == $past(count) + CW'(1)))
    else $error("append did not grow the list");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(count))
    else $error("count changed while busy");

endmodule
